// File: hw/rtl/fms_pkg.sv
// Shared types, codes and helpers of the flap and measure sequencer.
`default_nettype none
package fms_pkg;

    localparam int unsigned TOD_W      = 17;
    localparam int unsigned SLOT_W     = 9;
    localparam int unsigned BUF_DEPTH  = 256;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 10;
    localparam logic [TOD_W-1:0] DAY_SECONDS = 17'd86400;

    localparam logic [CFG_IDX_W-1:0] REG_FLAP_TIMEOUT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOG_INTERVAL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLOW_TIME     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MOIST_TIME    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MUTE_TICKS    = 3'd4;

    localparam logic [2:0] SEQ_INIT  = 3'd0;
    localparam logic [2:0] SEQ_FLOW  = 3'd1;
    localparam logic [2:0] SEQ_MOIST = 3'd2;
    localparam logic [2:0] SEQ_CLOSE = 3'd3;
    localparam logic [2:0] SEQ_OPEN  = 3'd4;

    localparam logic [1:0] FL_OPENED  = 2'd0;
    localparam logic [1:0] FL_OPENING = 2'd1;
    localparam logic [1:0] FL_CLOSED  = 2'd2;
    localparam logic [1:0] FL_CLOSING = 2'd3;

    localparam logic [2:0] FR_MOVING     = 3'd0;
    localparam logic [2:0] FR_DONE       = 3'd1;
    localparam logic [2:0] FR_OPEN_FAIL  = 3'd2;
    localparam logic [2:0] FR_CLOSE_FAIL = 3'd3;
    localparam logic [2:0] FR_NOT_ASKED  = 3'd4;

    localparam logic [1:0] LOG_NONE  = 2'd0;
    localparam logic [1:0] LOG_INFO  = 2'd1;
    localparam logic [1:0] LOG_FLOW  = 2'd2;
    localparam logic [1:0] LOG_MOIST = 2'd3;

    typedef struct packed {
        logic [1:0]       mode;
        logic             homing;
        logic [TOD_W-1:0] travel_start;
        logic             line_a;
        logic             line_b;
    } t_flap_st;

    // seconds from start to now, wrapping at midnight
    function automatic logic [TOD_W-1:0] elapsed(input logic [TOD_W-1:0] now,
                                                 input logic [TOD_W-1:0] start);
        logic [TOD_W-1:0] diff;
        diff = now - start;
        if (now < start) begin
            diff = diff + DAY_SECONDS;
        end
        return diff;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/fms_flap.sv
// Flap motor controller: homing, limit-switch arrival and travel timeout for one tick.
`default_nettype none
module fms_flap (
    input  fms_pkg::t_flap_st                 i_st,
    input  logic                              i_want_close,
    input  logic [fms_pkg::TOD_W-1:0]         i_now,
    input  logic                              i_open_n,
    input  logic                              i_closed_n,
    input  logic [7:0]                        i_timeout,
    output fms_pkg::t_flap_st                 o_st,
    output logic [2:0]                        o_fres,
    output logic                              o_mute_start
);
    import fms_pkg::*;

    logic w_expired;

    assign w_expired = elapsed(i_now, i_st.travel_start) > {{(TOD_W-8){1'b0}}, i_timeout};

    always_comb begin
        o_st         = i_st;
        o_fres       = FR_DONE;
        o_mute_start = 1'b0;
        unique case (i_st.mode)
            FL_OPENED: begin
                o_st.line_a = 1'b0;
                o_st.line_b = 1'b0;
                if (i_want_close) begin
                    o_st.line_a       = 1'b1;
                    o_st.line_b       = 1'b1;
                    o_st.travel_start = i_now;
                    o_st.mode         = FL_CLOSING;
                    o_mute_start      = 1'b1;
                    o_fres            = FR_MOVING;
                end else if (i_st.homing) begin
                    if (!i_open_n) begin
                        o_st.homing = 1'b0;
                    end else begin
                        o_st.line_a       = 1'b1;
                        o_st.mode         = FL_OPENING;
                        o_st.travel_start = i_now;
                        o_fres            = FR_MOVING;
                    end
                end
            end
            FL_CLOSED: begin
                o_st.line_a = 1'b0;
                o_st.line_b = 1'b0;
                if (!i_want_close) begin
                    o_st.line_a       = 1'b1;
                    o_st.travel_start = i_now;
                    o_st.mode         = FL_OPENING;
                    o_fres            = FR_MOVING;
                end
            end
            FL_OPENING: begin
                o_fres = FR_MOVING;
                if (!i_open_n) begin
                    o_st.mode   = FL_OPENED;
                    o_st.homing = 1'b0;
                end
                if (w_expired) begin
                    o_st.line_a = 1'b0;
                    o_st.line_b = 1'b0;
                    if (o_st.homing) begin
                        o_st.homing = 1'b0;
                        o_st.mode   = FL_OPENED;
                        o_fres      = FR_DONE;
                    end else begin
                        o_st.mode = FL_CLOSED;
                        o_fres    = FR_OPEN_FAIL;
                    end
                end
            end
            default: begin
                o_fres = FR_MOVING;
                if (!i_closed_n) begin
                    o_st.mode = FL_CLOSED;
                end
                if (w_expired) begin
                    o_st.line_a = 1'b0;
                    o_st.line_b = 1'b0;
                    o_st.mode   = FL_OPENED;
                    o_fres      = FR_CLOSE_FAIL;
                end
            end
        endcase
    end

endmodule
`default_nettype wire

// File: hw/rtl/flap_and_measure_sequencer.sv
// Top level: tick sequencer for flap travel, flow and moisture measurement and siren mute.
//
//  channel  direction  handshake                  payload
//  in       sink       i_in_valid / o_in_ready    time_of_day, open_limit_n, closed_limit_n
//  out      source     o_out_valid / i_out_ready  drive, mute, measure, slot, log, states
//  cfg      sink       i_cfg_wr_en (no wait)      i_cfg_idx, i_cfg_wdata
//
//  One tick per clock while the result is not stalled: each tick updates the state and loads
//  the result register in the cycle it is taken, so the result shows in the cycle after acceptance.
//  A new tick is taken while the result register is empty or being drained.
//  Reset is synchronous; the block is ready as soon as reset is released.
//  A stalled result holds, together with all state, until it is taken.
`default_nettype none
module flap_and_measure_sequencer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [fms_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [fms_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [16:0]                       i_time_of_day,
    input  logic                              i_open_limit_n,
    input  logic                              i_closed_limit_n,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_drive_open,
    output logic                              o_drive_close,
    output logic                              o_siren_muted,
    output logic                              o_measure_now,
    output logic                              o_measure_with_cvd,
    output logic [8:0]                        o_sample_slot,
    output logic [1:0]                        o_log_kind,
    output logic [2:0]                        o_sequence_state,
    output logic [1:0]                        o_flap_state,
    output logic [2:0]                        o_flap_result
);
    import fms_pkg::*;

    logic [7:0]        r_flap_timeout;
    logic [7:0]        r_log_interval;
    logic [9:0]        r_flow_time;
    logic [9:0]        r_moist_time;
    logic [7:0]        r_mute_ticks;

    logic [2:0]        r_seq, n_seq;
    t_flap_st          r_flap, n_flap;
    logic [TOD_W-1:0]  r_phase_start, n_phase_start;
    logic [TOD_W-1:0]  r_flush_start, n_flush_start;
    logic [SLOT_W-1:0] r_slot_count, n_slot_count;
    logic              r_mute_active, n_mute_active;
    logic [7:0]        r_mute_left, n_mute_left;

    logic              r_out_valid;
    logic              r_meas, n_meas;
    logic              r_cvd, n_cvd;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [1:0]        r_logk, n_logk;
    logic [2:0]        r_fres, n_fres;

    logic              w_accept;
    logic [TOD_W-1:0]  w_now;
    logic              w_want_close;
    t_flap_st          w_flap_next;
    logic [2:0]        w_flap_fres;
    logic              w_mute_start;
    logic              w_flow;
    logic [9:0]        w_limit;
    logic [15:0]       w_flush_span;
    logic [15:0]       w_phase_span;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_now = (i_time_of_day >= DAY_SECONDS) ? i_time_of_day - DAY_SECONDS
                                                  : i_time_of_day;

    assign w_want_close = (r_seq == SEQ_CLOSE);
    assign w_flow       = (r_seq == SEQ_FLOW);
    assign w_limit      = w_flow ? r_flow_time : r_moist_time;
    // times sixty as (x << 6) - (x << 2)
    assign w_flush_span = {2'b00, r_log_interval, 6'd0} - {6'd0, r_log_interval, 2'd0};
    assign w_phase_span = {w_limit, 6'd0} - {4'd0, w_limit, 2'd0};

    fms_flap u_flap (
        .i_st         (r_flap),
        .i_want_close (w_want_close),
        .i_now        (w_now),
        .i_open_n     (i_open_limit_n),
        .i_closed_n   (i_closed_limit_n),
        .i_timeout    (r_flap_timeout),
        .o_st         (w_flap_next),
        .o_fres       (w_flap_fres),
        .o_mute_start (w_mute_start)
    );

    always_comb begin
        n_seq         = r_seq;
        n_flap        = r_flap;
        n_phase_start = r_phase_start;
        n_flush_start = r_flush_start;
        n_slot_count  = r_slot_count;
        n_mute_active = r_mute_active;
        n_mute_left   = r_mute_left;
        n_meas        = 1'b0;
        n_cvd         = 1'b0;
        n_slot        = '0;
        n_logk        = LOG_NONE;
        n_fres        = FR_NOT_ASKED;

        if (r_mute_active) begin
            n_mute_left = r_mute_left - 8'd1;
            if (n_mute_left == 8'd0) begin
                n_mute_active = 1'b0;
            end
        end

        unique case (r_seq)
            SEQ_INIT: begin
                n_logk = LOG_INFO;
                n_seq  = SEQ_OPEN;
            end
            SEQ_FLOW, SEQ_MOIST: begin
                if (r_slot_count < SLOT_W'(BUF_DEPTH)) begin
                    n_slot_count = r_slot_count + SLOT_W'(1);
                end
                n_meas = 1'b1;
                n_cvd  = w_flow;
                n_slot = n_slot_count;
                if (elapsed(w_now, r_flush_start) >= {1'b0, w_flush_span}) begin
                    n_logk        = w_flow ? LOG_FLOW : LOG_MOIST;
                    n_flush_start = w_now;
                    n_slot_count  = '0;
                end
                if (elapsed(w_now, r_phase_start) >= {1'b0, w_phase_span}) begin
                    n_seq = w_flow ? SEQ_CLOSE : SEQ_OPEN;
                end
            end
            SEQ_CLOSE, SEQ_OPEN: begin
                n_flap = w_flap_next;
                n_fres = w_flap_fres;
                if (w_mute_start) begin
                    n_mute_active = 1'b1;
                    n_mute_left   = r_mute_ticks;
                end
                if (w_flap_fres == FR_DONE) begin
                    n_seq         = w_want_close ? SEQ_MOIST : SEQ_FLOW;
                    n_phase_start = w_now;
                    n_flush_start = w_now;
                end else if (w_flap_fres == FR_CLOSE_FAIL && w_want_close) begin
                    n_seq         = SEQ_FLOW;
                    n_phase_start = w_now;
                    n_flush_start = w_now;
                end else if (w_flap_fres == FR_OPEN_FAIL && !w_want_close) begin
                    n_seq         = SEQ_MOIST;
                    n_phase_start = w_now;
                    n_flush_start = w_now;
                    n_logk        = LOG_INFO;
                end
            end
            default: begin
                n_seq = SEQ_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flap_timeout <= 8'd30;
            r_log_interval <= 8'd10;
            r_flow_time    <= 10'd60;
            r_moist_time   <= 10'd60;
            r_mute_ticks   <= 8'd45;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                REG_FLAP_TIMEOUT: r_flap_timeout <= i_cfg_wdata[7:0];
                REG_LOG_INTERVAL: r_log_interval <= i_cfg_wdata[7:0];
                REG_FLOW_TIME:    r_flow_time    <= i_cfg_wdata;
                REG_MOIST_TIME:   r_moist_time   <= i_cfg_wdata;
                REG_MUTE_TICKS:   r_mute_ticks   <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq         <= SEQ_INIT;
            r_flap        <= '{mode: FL_OPENED, homing: 1'b1, travel_start: '0,
                               line_a: 1'b0, line_b: 1'b0};
            r_phase_start <= '0;
            r_flush_start <= '0;
            r_slot_count  <= '0;
            r_mute_active <= 1'b0;
            r_mute_left   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_accept) begin
                r_seq         <= n_seq;
                r_flap        <= n_flap;
                r_phase_start <= n_phase_start;
                r_flush_start <= n_flush_start;
                r_slot_count  <= n_slot_count;
                r_mute_active <= n_mute_active;
                r_mute_left   <= n_mute_left;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_meas <= n_meas;
            r_cvd  <= n_cvd;
            r_slot <= n_slot;
            r_logk <= n_logk;
            r_fres <= n_fres;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_drive_open       = r_flap.line_a;
    assign o_drive_close      = r_flap.line_b;
    assign o_siren_muted      = r_mute_active;
    assign o_measure_now      = r_meas;
    assign o_measure_with_cvd = r_cvd;
    assign o_sample_slot      = r_slot;
    assign o_log_kind         = r_logk;
    assign o_sequence_state   = r_seq;
    assign o_flap_state       = r_flap.mode;
    assign o_flap_result      = r_fres;

    a_close_needs_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_drive_close |-> o_drive_open)
        else $error("close drive without open drive");

    a_idle_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_measure_now |-> o_sample_slot == '0 && !o_measure_with_cvd)
        else $error("slot or cvd set without a measurement");

    a_meas_slot_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_measure_now |-> o_sample_slot != '0)
        else $error("measurement without a buffer slot");

    a_mute_on_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_mute_start |=> r_mute_active && r_flap.mode == FL_CLOSING)
        else $error("close start did not arm the siren mute");

endmodule
`default_nettype wire
